[src/pdbs_pkg.sv]
// shared types and constants for the packet dispatch scoreboard
// no dependencies; imported by pdbs_ctrl, pdbs_datapath and the top level
package pdbs_pkg;

    localparam int SLOTS    = 64;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int MODE_W   = 3;
    localparam int TYPE_W   = 5;
    localparam int PEER_W   = 6;
    localparam int ID_W     = 64;
    localparam int LEVEL_W  = 64;
    localparam int STATUS_W = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_QUERY        = 3'd0,
        MODE_HARD_MARK    = 3'd1,
        MODE_HARD_UNMARK  = 3'd2,
        MODE_PEER_MARK    = 3'd3,
        MODE_PEER_UNMARK  = 3'd4,
        MODE_LEVEL_SET    = 3'd5,
        MODE_LEVEL_UNSET  = 3'd6
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_DUP     = 3'd1,
        ST_MISSING = 3'd2,
        ST_FULL    = 3'd3,
        ST_LEVEL   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        KIND_HARD  = 2'd0,
        KIND_PEER  = 2'd1,
        KIND_LEVEL = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [TYPE_W-1:0]   slot_type;
        logic [PEER_W-1:0]   peer;
        logic [ID_W-1:0]     id;
        logic [LEVEL_W-1:0]  level;
    } slot_t;

    localparam int SLOT_BITS = $bits(slot_t);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic issue;
        logic commit;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic issue_last;
        logic out_free;
    } dp_stat_t;

endpackage

[src/pdbs_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module pdbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/pdbs_ctrl.sv]
// sequencing state machine for the scoreboard: accept, scan, drain, commit
// depends on pdbs_pkg
module pdbs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pdbs_pkg::dp_stat_t  stat,
    output pdbs_pkg::ctrl_cmd_t cmd
);
    import pdbs_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_SCAN;
            end
            S_SCAN: begin
                if (stat.issue_last) state_next = S_DRAIN;
            end
            S_DRAIN: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            S_SCAN: begin
                cmd.issue = 1'b1;
            end
            S_DRAIN: begin
            end
            S_DONE: begin
                cmd.commit = stat.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

[src/pdbs_datapath.sv]
// item registers, slot store, scan evaluation, result resolve and output word
// depends on pdbs_pkg and pdbs_ram
module pdbs_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pdbs_pkg::ctrl_cmd_t           cmd,
    output pdbs_pkg::dp_stat_t            stat,
    input  logic                          cfg_wr_en,
    input  logic [pdbs_pkg::TYPE_W-1:0]   cfg_wr_data,
    input  logic [pdbs_pkg::MODE_W-1:0]   s_mode,
    input  logic [pdbs_pkg::ID_W-1:0]     s_packet_id,
    input  logic [pdbs_pkg::TYPE_W-1:0]   s_packet_type,
    input  logic [pdbs_pkg::TYPE_W-1:0]   s_target_type,
    input  logic [pdbs_pkg::PEER_W-1:0]   s_peer_index,
    input  logic [pdbs_pkg::LEVEL_W-1:0]  s_dag_level,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_blocked,
    output logic [pdbs_pkg::STATUS_W-1:0] m_status
);
    import pdbs_pkg::*;

    // captured word and new-block type
    logic [MODE_W-1:0]  mode_reg;
    logic [ID_W-1:0]    id_reg;
    logic [TYPE_W-1:0]  ptype_reg;
    logic [TYPE_W-1:0]  ttype_reg;
    logic [PEER_W-1:0]  peer_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [TYPE_W-1:0]  nbt_reg;

    // scan
    logic [SLOT_W-1:0]  scan_idx_reg;
    logic               eval_live_reg;
    logic               eval_vld_reg;
    logic [SLOT_W-1:0]  eval_idx_reg;
    logic [SLOTS-1:0]   valid_reg, valid_next;

    // accumulated flags
    logic               hard_reg, order_reg, equal_reg, below_reg;
    logic               match_reg, free_reg;
    logic [SLOT_W-1:0]  match_idx_reg, free_idx_reg;

    // output word
    logic               m_valid_reg;
    logic               blocked_reg;
    status_t            status_reg;

    logic [SLOT_BITS-1:0] ram_rdata;
    slot_t              rd, wr;
    kind_t              key_kind;
    logic               hit, key_eq;
    logic               e_hard, e_peer, e_below, e_match, e_free;
    logic               blocked_n, do_write, do_clear;
    status_t            status_n;

    pdbs_ram #(
        .WIDTH (SLOT_BITS),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (cmd.commit && do_write),
        .waddr (free_idx_reg),
        .wdata (wr),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    // per-slot evaluation of the word read back
    always_comb begin
        rd = slot_t'(ram_rdata);
        unique case (mode_reg) inside
            MODE_HARD_MARK, MODE_HARD_UNMARK: key_kind = KIND_HARD;
            MODE_PEER_MARK, MODE_PEER_UNMARK: key_kind = KIND_PEER;
            default:                          key_kind = KIND_LEVEL;
        endcase
        case (key_kind)
            KIND_HARD: key_eq = (rd.slot_type == ttype_reg);
            KIND_PEER: key_eq = (rd.slot_type == ttype_reg) && (rd.peer == peer_reg);
            default:   key_eq = (rd.level == level_reg);
        endcase
        hit     = eval_live_reg && eval_vld_reg;
        e_hard  = hit && (rd.kind == KIND_HARD) && (rd.slot_type == ptype_reg);
        e_peer  = hit && (rd.kind == KIND_PEER) && (rd.slot_type == ptype_reg)
                  && (rd.peer == peer_reg);
        e_below = hit && (rd.kind == KIND_LEVEL) && (rd.level < level_reg);
        e_match = hit && (rd.kind == key_kind) && (rd.id == id_reg) && key_eq;
        e_free  = eval_live_reg && !eval_vld_reg;

        wr.kind      = key_kind;
        wr.slot_type = ttype_reg;
        wr.peer      = peer_reg;
        wr.id        = id_reg;
        wr.level     = level_reg;
    end

    // final answer from the accumulated flags
    always_comb begin
        blocked_n = 1'b0;
        status_n  = ST_OK;
        do_write  = 1'b0;
        do_clear  = 1'b0;
        unique case (mode_reg) inside
            MODE_QUERY: begin
                if (hard_reg || ((ptype_reg == nbt_reg) && below_reg) || order_reg) begin
                    blocked_n = 1'b1;
                end else if (equal_reg) begin
                    status_n = ST_DUP;
                end
            end
            MODE_HARD_MARK, MODE_PEER_MARK, MODE_LEVEL_SET: begin
                if ((mode_reg == MODE_LEVEL_SET) && below_reg) begin
                    status_n = ST_LEVEL;
                end else if (match_reg) begin
                    status_n = ST_DUP;
                end else if (!free_reg) begin
                    status_n = ST_FULL;
                end else begin
                    do_write = 1'b1;
                end
            end
            MODE_HARD_UNMARK, MODE_PEER_UNMARK, MODE_LEVEL_UNSET: begin
                if (!match_reg) begin
                    status_n = ST_MISSING;
                end else begin
                    do_clear = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (cmd.commit && do_write) valid_next[free_idx_reg] = 1'b1;
        if (cmd.commit && do_clear) valid_next[match_idx_reg] = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg  <= s_mode;
            id_reg    <= s_packet_id;
            ptype_reg <= s_packet_type;
            ttype_reg <= s_target_type;
            peer_reg  <= s_peer_index;
            level_reg <= s_dag_level;
        end
        if (cmd.issue) begin
            eval_idx_reg <= scan_idx_reg;
            eval_vld_reg <= valid_reg[scan_idx_reg];
        end
        if (e_match && !match_reg) match_idx_reg <= eval_idx_reg;
        if (e_free && !free_reg)   free_idx_reg  <= eval_idx_reg;
        if (cmd.commit) begin
            blocked_reg <= blocked_n;
            status_reg  <= status_n;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nbt_reg       <= '0;
            valid_reg     <= '0;
            scan_idx_reg  <= '0;
            eval_live_reg <= 1'b0;
            hard_reg      <= 1'b0;
            order_reg     <= 1'b0;
            equal_reg     <= 1'b0;
            below_reg     <= 1'b0;
            match_reg     <= 1'b0;
            free_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) nbt_reg <= cfg_wr_data;
            valid_reg     <= valid_next;
            eval_live_reg <= cmd.issue;
            if (cmd.capture) begin
                scan_idx_reg <= '0;
                hard_reg     <= 1'b0;
                order_reg    <= 1'b0;
                equal_reg    <= 1'b0;
                below_reg    <= 1'b0;
                match_reg    <= 1'b0;
                free_reg     <= 1'b0;
            end else begin
                if (cmd.issue) scan_idx_reg <= scan_idx_reg + 1'b1;
                if (e_hard)                       hard_reg  <= 1'b1;
                if (e_peer && (rd.id < id_reg))   order_reg <= 1'b1;
                if (e_peer && (rd.id == id_reg))  equal_reg <= 1'b1;
                if (e_below)                      below_reg <= 1'b1;
                if (e_match)                      match_reg <= 1'b1;
                if (e_free)                       free_reg  <= 1'b1;
            end
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.issue_last = (scan_idx_reg == SLOT_W'(SLOTS - 1));
    assign stat.out_free   = !m_valid_reg || m_ready;

    assign m_valid   = m_valid_reg;
    assign m_blocked = blocked_reg;
    assign m_status  = status_reg;

endmodule

[src/packet_dispatch_block_scoreboard.sv]
// top level of the packet dispatch scoreboard
// depends on pdbs_pkg, pdbs_ctrl, pdbs_datapath (which holds pdbs_ram)
//
// usage:
//   input channel s_*: one word per event; s_mode selects query, hard
//   mark/unmark, peer mark/unmark or level set/unset; the other fields carry
//   the id, types, peer index and level that the event needs
//   result channel m_*: exactly one word per input word, m_blocked (queries
//   only) and m_status
//   cfg_wr_en/cfg_wr_data: writes the new-block type; use only while idle, not enforced
// timing:
//   every event walks all SLOTS entries of the slot ram, one read port, one
//   entry per cycle; after the scan come a drain step and a commit step that
//   registers the result word, then the block returns to idle; it takes no
//   new word until the result of the last one is committed
//   the result sits in an output register; if the receiver stalls, the
//   block finishes its scan and holds in its last step, committing any table
//   change only when the output register is free
// reset:
//   synchronous, active low; clears all slot valid bits and the new-block
//   type at once, no clearing pass; slot contents need no reset
module packet_dispatch_block_scoreboard (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [pdbs_pkg::TYPE_W-1:0]   cfg_wr_data,
    // event words
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [pdbs_pkg::MODE_W-1:0]   s_mode,
    input  logic [pdbs_pkg::ID_W-1:0]     s_packet_id,
    input  logic [pdbs_pkg::TYPE_W-1:0]   s_packet_type,
    input  logic [pdbs_pkg::TYPE_W-1:0]   s_target_type,
    input  logic [pdbs_pkg::PEER_W-1:0]   s_peer_index,
    input  logic [pdbs_pkg::LEVEL_W-1:0]  s_dag_level,
    // result words
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_blocked,
    output logic [pdbs_pkg::STATUS_W-1:0] m_status
);
    import pdbs_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // sequencer: idle, scan all slots, drain the read pipe, commit
    pdbs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // slot store, compare logic and output register
    pdbs_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_mode        (s_mode),
        .s_packet_id   (s_packet_id),
        .s_packet_type (s_packet_type),
        .s_target_type (s_target_type),
        .s_peer_index  (s_peer_index),
        .s_dag_level   (s_dag_level),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_blocked     (m_blocked),
        .m_status      (m_status)
    );

    // a taken word starts a scan, so no second word right behind it
    a_no_back_to_back: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a scan is running");

    // a result only appears at the end of a scan, never while idle
    a_result_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result word without a finished scan");

    // a blocked answer never carries an error status
    a_blocked_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_blocked |-> m_status == ST_OK)
        else $error("blocked answer with nonzero status");

    // status codes stay within the defined set
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= ST_LEVEL)
        else $error("undefined status code");

endmodule
